### rtl/core/isotp_cf_pkg.sv
// Shared types, codes and sizes for the ISO-TP reassembly and current filter.
// No dependencies.
package isotp_cf_pkg;

    localparam int PAYLOAD_BYTES = 64;
    localparam int NUM_BANKS     = 8;
    localparam int BANK_ROWS     = PAYLOAD_BYTES / NUM_BANKS;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int LEN_W         = IDX_W + 1;
    localparam int BANK_W        = $clog2(NUM_BANKS);
    localparam int ROW_W         = $clog2(BANK_ROWS);

    localparam int FILT_W        = 24;
    localparam int GAIN_W        = 17;
    localparam int THR_W         = 23;

    localparam logic [7:0]        RST_RESPONSE_SID   = 8'h62;
    localparam logic [15:0]       RST_DATA_ID        = 16'h1F9A;
    localparam logic [IDX_W-1:0]  RST_CURRENT_OFFSET = IDX_W'(7);
    localparam logic [GAIN_W-1:0] RST_FILTER_GAIN    = GAIN_W'(9830);
    localparam logic [THR_W-1:0]  RST_DIR_THRESHOLD  = THR_W'(512);
    localparam logic [GAIN_W-1:0] GAIN_UNITY         = GAIN_W'(65536);

    typedef enum logic [2:0] {
        CFG_RESPONSE_SID = 3'd0,
        CFG_DATA_ID      = 3'd1,
        CFG_CUR_OFFSET   = 3'd2,
        CFG_FILTER_GAIN  = 3'd3,
        CFG_DIR_THRESH   = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        PCI_SINGLE = 4'h0,
        PCI_FIRST  = 4'h1,
        PCI_CONSEC = 4'h2
    } pci_type_t;

    typedef enum logic [1:0] {
        KIND_SINGLE  = 2'd0,
        KIND_FIRST   = 2'd1,
        KIND_CONSEC  = 2'd2,
        KIND_IGNORED = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        DIR_IDLE      = 2'd0,
        DIR_DISCHARGE = 2'd1,
        DIR_CHARGE    = 2'd2
    } direction_t;

endpackage

### rtl/core/isotp_reassembly_current_filter_top.sv
// ISO-TP reassembly, current word extraction and low-pass filter, top level.
// Depends on isotp_cf_pkg.
//
// One decoded 8-byte CAN frame is taken per item and one result item is given per
// frame, at a sustained rate of one item per clock while m_tready is held high. An
// item passes the input register, which loads at the edge that accepts it, then
// reassembly with payload bank write/read, filter update and the output register,
// each registered, before it is offered on the result side. The rate is set by
// the filter feedback loop, one 25x18 multiply-accumulate and clamp per cycle,
// and by the payload store, which is eight 8-row banks so that the up to seven
// bytes of one frame are written in the same cycle. Configuration writes take
// effect at once and should be made with no items in flight.
module isotp_reassembly_current_filter_top
    import isotp_cf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // byte_0 .. byte_7, 8 bits each

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // raw_current[15:0], filtered_current[39:16],
                                   // direction[41:40], zero fill
    output logic [2:0]  m_tuser    // frame_kind[1:0], reading_valid[2]
);

    // configuration
    logic [7:0]        response_sid_reg;
    logic [15:0]       data_id_reg;
    logic [IDX_W-1:0]  cur_offset_reg;
    logic [GAIN_W-1:0] filter_gain_reg;
    logic [THR_W-1:0]  dir_thresh_reg;

    // pipeline control
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic do1, do2;

    // stage 0: input register
    logic [7:0] in_byte_reg [8];

    // reassembly state
    logic             collecting_reg;
    logic [LEN_W-1:0] exp_len_reg;
    logic [LEN_W-1:0] rec_len_reg;
    logic [7:0]       hdr_reg [3];

    logic             collecting_next;
    logic [LEN_W-1:0] exp_len_next;
    logic [LEN_W-1:0] rec_len_next;
    logic [7:0]       hdr_next [3];
    frame_kind_t      kind_next;
    logic             match_next;

    // byte writes of the current frame
    logic [LEN_W-1:0] wr_base;
    logic [2:0]       wr_cnt;
    logic [7:0]       wr_src [7];
    logic [11:0]      ff_len;
    logic [3:0]       sf_len;
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] hdr_rel [3];

    // payload banks
    logic [7:0]       bank_mem_reg [NUM_BANKS][BANK_ROWS];
    logic [7:0]       bank_rd_reg  [NUM_BANKS];
    logic             bank_we      [NUM_BANKS];
    logic [ROW_W-1:0] bank_waddr   [NUM_BANKS];
    logic [ROW_W-1:0] bank_raddr   [NUM_BANKS];
    logic [7:0]       bank_wdata   [NUM_BANKS];
    logic [BANK_W-1:0] bank_j      [NUM_BANKS];
    logic [LEN_W-1:0] bank_idx     [NUM_BANKS];
    logic [IDX_W-1:0] offset_p1;

    // stage 1 result
    frame_kind_t s1_kind_reg;
    logic        s1_match_reg;

    // stage 2: filter
    logic signed [FILT_W-1:0] filter_reg;
    logic signed [15:0]       raw_cur;
    logic signed [FILT_W-1:0] x_val;
    logic signed [FILT_W:0]   diff;
    logic [GAIN_W-1:0]        gain_sat;
    logic signed [42:0]       prod;
    logic signed [43:0]       acc;
    logic signed [27:0]       f_round;
    logic signed [FILT_W-1:0] f_new;
    logic [BANK_W-1:0]        hi_bank;
    logic [BANK_W-1:0]        lo_bank;

    frame_kind_t              s2_kind_reg;
    logic                     s2_valid_reg;
    logic signed [15:0]       s2_raw_reg;
    logic signed [FILT_W-1:0] s2_filt_reg;

    // stage 3: output
    frame_kind_t              m_kind_reg;
    logic                     m_valid_flag_reg;
    logic signed [15:0]       m_raw_reg;
    logic signed [FILT_W-1:0] m_filt_reg;
    direction_t               m_dir_reg;
    direction_t               dir_next;
    logic signed [THR_W:0]    thr_pos;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;
    assign do1      = v0_reg && rdy1;
    assign do2      = v1_reg && rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            response_sid_reg <= RST_RESPONSE_SID;
            data_id_reg      <= RST_DATA_ID;
            cur_offset_reg   <= RST_CURRENT_OFFSET;
            filter_gain_reg  <= RST_FILTER_GAIN;
            dir_thresh_reg   <= RST_DIR_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESPONSE_SID: response_sid_reg <= cfg_data[7:0];
                CFG_DATA_ID:      data_id_reg      <= cfg_data[15:0];
                CFG_CUR_OFFSET:   cur_offset_reg   <= cfg_data[IDX_W-1:0];
                CFG_FILTER_GAIN:  filter_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_DIR_THRESH:   dir_thresh_reg   <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_tready) v0_reg <= s_tvalid;
            if (rdy1)     v1_reg <= v0_reg;
            if (rdy2)     v2_reg <= v1_reg;
            if (rdy3)     v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            for (int i = 0; i < 8; i++) begin
                in_byte_reg[i] <= s_tdata[8*i +: 8];
            end
        end
    end

    // reassembly
    always_comb begin
        sf_len          = in_byte_reg[0][3:0];
        ff_len          = {in_byte_reg[0][3:0], in_byte_reg[1]};
        room            = exp_len_reg - rec_len_reg;
        collecting_next = collecting_reg;
        exp_len_next    = exp_len_reg;
        rec_len_next    = rec_len_reg;
        kind_next       = KIND_IGNORED;
        wr_base         = '0;
        wr_cnt          = '0;
        for (int i = 0; i < 7; i++) begin
            wr_src[i] = in_byte_reg[i+1];
        end

        case (in_byte_reg[0][7:4])
            PCI_SINGLE: begin
                if (sf_len >= 4'd1 && sf_len <= 4'd7) begin
                    exp_len_next    = LEN_W'(sf_len);
                    rec_len_next    = LEN_W'(sf_len);
                    wr_cnt          = sf_len[2:0];
                    collecting_next = 1'b0;
                    kind_next       = KIND_SINGLE;
                end
            end
            PCI_FIRST: begin
                for (int i = 0; i < 6; i++) begin
                    wr_src[i] = in_byte_reg[i+2];
                end
                if (ff_len >= 12'd1 && ff_len <= 12'(PAYLOAD_BYTES)) begin
                    wr_cnt          = (ff_len >= 12'd6) ? 3'd6 : ff_len[2:0];
                    exp_len_next    = ff_len[LEN_W-1:0];
                    rec_len_next    = LEN_W'(wr_cnt);
                    collecting_next = 1'b1;
                    kind_next       = KIND_FIRST;
                end
            end
            PCI_CONSEC: begin
                if (collecting_reg) begin
                    wr_base      = rec_len_reg;
                    wr_cnt       = (room >= LEN_W'(7)) ? 3'd7 : room[2:0];
                    rec_len_next = rec_len_reg + LEN_W'(wr_cnt);
                    if (rec_len_next >= exp_len_reg) collecting_next = 1'b0;
                    kind_next    = KIND_CONSEC;
                end
            end
            default: ;
        endcase

        for (int k = 0; k < 3; k++) begin
            hdr_rel[k]  = LEN_W'(k) - wr_base;
            hdr_next[k] = hdr_reg[k];
            if (wr_base <= LEN_W'(k) && hdr_rel[k] < LEN_W'(wr_cnt)) begin
                hdr_next[k] = wr_src[hdr_rel[k][2:0]];
            end
        end

        match_next = (exp_len_next != '0) && (rec_len_next >= exp_len_next) &&
                     (exp_len_next >= LEN_W'(3)) &&
                     (exp_len_next >= LEN_W'(cur_offset_reg) + LEN_W'(2)) &&
                     (hdr_next[0] == response_sid_reg) &&
                     ({hdr_next[1], hdr_next[2]} == data_id_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            exp_len_reg    <= '0;
            rec_len_reg    <= '0;
        end else if (do1) begin
            if (match_next) begin
                collecting_reg <= 1'b0;
                exp_len_reg    <= '0;
                rec_len_reg    <= '0;
            end else begin
                collecting_reg <= collecting_next;
                exp_len_reg    <= exp_len_next;
                rec_len_reg    <= rec_len_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do1) begin
            for (int k = 0; k < 3; k++) begin
                hdr_reg[k] <= hdr_next[k];
            end
            s1_kind_reg  <= kind_next;
            s1_match_reg <= match_next;
        end
    end

    // payload banks: byte index i lives in bank i mod 8, row i div 8
    assign offset_p1 = cur_offset_reg + IDX_W'(1);

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_j[b]     = BANK_W'(b) - wr_base[BANK_W-1:0];
            bank_idx[b]   = wr_base + LEN_W'(bank_j[b]);
            bank_we[b]    = do1 && (3'(bank_j[b]) < wr_cnt);
            bank_waddr[b] = bank_idx[b][IDX_W-1:BANK_W];
            bank_wdata[b] = (bank_j[b] == BANK_W'(7)) ? wr_src[0] : wr_src[bank_j[b][2:0]];
            bank_raddr[b] = (cur_offset_reg[BANK_W-1:0] == BANK_W'(b)) ?
                            cur_offset_reg[IDX_W-1:BANK_W] : offset_p1[IDX_W-1:BANK_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (do1) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                if (bank_we[b]) bank_mem_reg[b][bank_waddr[b]] <= bank_wdata[b];
                if (bank_we[b] && bank_waddr[b] == bank_raddr[b]) begin
                    bank_rd_reg[b] <= bank_wdata[b];
                end else begin
                    bank_rd_reg[b] <= bank_mem_reg[b][bank_raddr[b]];
                end
            end
        end
    end

    // filter: f' = floor((65536*f + g*(x - f) + 32768) / 65536), clamped
    always_comb begin
        hi_bank  = cur_offset_reg[BANK_W-1:0];
        lo_bank  = offset_p1[BANK_W-1:0];
        raw_cur  = s1_match_reg ? $signed({bank_rd_reg[hi_bank], bank_rd_reg[lo_bank]})
                                : 16'sd0;
        x_val    = {raw_cur, 8'h00};
        diff     = (FILT_W+1)'(x_val) - (FILT_W+1)'(filter_reg);
        gain_sat = (filter_gain_reg > GAIN_UNITY) ? GAIN_UNITY : filter_gain_reg;
        prod     = $signed({1'b0, gain_sat}) * diff;
        acc      = {{4{filter_reg[FILT_W-1]}}, filter_reg, 16'h0000} + 44'(prod)
                   + 44'sd32768;
        f_round  = acc[43:16];
        if (f_round > 28'sh07F_FFFF) begin
            f_new = 24'sh7F_FFFF;
        end else if (f_round < -28'sh080_0000) begin
            f_new = -24'sh80_0000;
        end else begin
            f_new = f_round[FILT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else if (do2 && s1_match_reg) begin
            filter_reg <= f_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (do2) begin
            s2_kind_reg  <= s1_kind_reg;
            s2_valid_reg <= s1_match_reg;
            s2_raw_reg   <= raw_cur;
            s2_filt_reg  <= s1_match_reg ? f_new : filter_reg;
        end
    end

    // direction class and output register
    always_comb begin
        thr_pos = $signed({1'b0, dir_thresh_reg});
        if (s2_filt_reg > thr_pos) begin
            dir_next = DIR_DISCHARGE;
        end else if (s2_filt_reg < -thr_pos) begin
            dir_next = DIR_CHARGE;
        end else begin
            dir_next = DIR_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            m_kind_reg       <= s2_kind_reg;
            m_valid_flag_reg <= s2_valid_reg;
            m_raw_reg        <= s2_raw_reg;
            m_filt_reg       <= s2_filt_reg;
            m_dir_reg        <= dir_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {6'b0, m_dir_reg, m_filt_reg, m_raw_reg};
    assign m_tuser  = {m_valid_flag_reg, m_kind_reg};

endmodule
